### rtl/core/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check on a clock, masked while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication check: consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication check: consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hrgb_pkg.sv
// shared types and constants for the hue ramp hsv to rgb core
// no dependencies
package hrgb_pkg;

    // default fraction width of every value
    localparam int unsigned FRACTION_BITS_DEF = 16;

    // configuration register index
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_START  = 3'd0,
        CFG_HUE_SPAN   = 3'd1,
        CFG_SATURATION = 3'd2,
        CFG_BRIGHTNESS = 3'd3
    } t_cfg_idx;

    // hue sector, 0 to 5
    localparam int unsigned SECTOR_W = 3;

    localparam logic [SECTOR_W-1:0] SECTOR_0 = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_1 = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_2 = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_3 = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_4 = 3'd4;

    // register stages from input beat to output beat
    localparam int unsigned PIPE_DEPTH = 6;

endpackage

### rtl/core/hrgb_cfg_regs.sv
// configuration register file: hue start, hue span, saturation, brightness
// depends on hrgb_pkg
module hrgb_cfg_regs #(
    parameter int unsigned FRACTION_BITS = hrgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hrgb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [FRACTION_BITS-1:0]         i_cfg_data,
    output logic [FRACTION_BITS-1:0]         o_hue_start,
    output logic [FRACTION_BITS-1:0]         o_hue_span,
    output logic [FRACTION_BITS-1:0]         o_saturation,
    output logic [FRACTION_BITS-1:0]         o_brightness
);
    import hrgb_pkg::*;

    // one half
    localparam logic [FRACTION_BITS-1:0] HALF = {1'b1, {(FRACTION_BITS-1){1'b0}}};

    logic [FRACTION_BITS-1:0] r_hue_start;
    logic [FRACTION_BITS-1:0] r_hue_span;
    logic [FRACTION_BITS-1:0] r_saturation;
    logic [FRACTION_BITS-1:0] r_brightness;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_start  <= HALF;
            r_hue_span   <= HALF;
            r_saturation <= HALF;
            r_brightness <= HALF;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HUE_START:  r_hue_start  <= i_cfg_data;
                CFG_HUE_SPAN:   r_hue_span   <= i_cfg_data;
                CFG_SATURATION: r_saturation <= i_cfg_data;
                CFG_BRIGHTNESS: r_brightness <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_hue_start  = r_hue_start;
    assign o_hue_span   = r_hue_span;
    assign o_saturation = r_saturation;
    assign o_brightness = r_brightness;

endmodule

### rtl/core/hrgb_hue_pipe.sv
// stages 1 to 3: hue from ramp position, then sector and fraction
// depends on hrgb_pkg
module hrgb_hue_pipe #(
    parameter int unsigned FRACTION_BITS = hrgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [FRACTION_BITS-1:0]         i_pos,
    input  logic [FRACTION_BITS-1:0]         i_hue_start,
    input  logic [FRACTION_BITS-1:0]         i_hue_span,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [hrgb_pkg::SECTOR_W-1:0]    o_sector,
    output logic [FRACTION_BITS-1:0]         o_frac
);
    import hrgb_pkg::*;

    localparam int unsigned PW = 2 * FRACTION_BITS;
    localparam int unsigned HW = FRACTION_BITS + SECTOR_W;

    logic                     r_v1, r_v2, r_v3;
    logic                     en1, en2, en3;
    logic [PW-1:0]            r_prod, n_prod;
    logic [FRACTION_BITS-1:0] r_hue, n_hue;
    logic [HW-1:0]            n_h6;
    logic [SECTOR_W-1:0]      r_sector;
    logic [FRACTION_BITS-1:0] r_frac;

    // stall chain: a stage loads when empty or when its successor moves
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // stage 1: position times span
    assign n_prod = PW'(i_pos) * PW'(i_hue_span);
    // stage 2: add start, wrap modulo one
    assign n_hue  = i_hue_start + r_prod[PW-1:FRACTION_BITS];
    // stage 3: times six as two shifts and an add
    assign n_h6   = (HW'(r_hue) << 2) + (HW'(r_hue) << 1);

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) r_prod <= n_prod;
        if (en2 && r_v1)    r_hue  <= n_hue;
        if (en3 && r_v2) begin
            r_sector <= n_h6[HW-1:FRACTION_BITS];
            r_frac   <= n_h6[FRACTION_BITS-1:0];
        end
    end

    assign o_valid  = r_v3;
    assign o_sector = r_sector;
    assign o_frac   = r_frac;

endmodule

### rtl/core/hrgb_rgb_pipe.sv
// stages 4 to 6: p, q, t terms and per-sector channel select
// depends on hrgb_pkg
module hrgb_rgb_pipe #(
    parameter int unsigned FRACTION_BITS = hrgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [hrgb_pkg::SECTOR_W-1:0]    i_sector,
    input  logic [FRACTION_BITS-1:0]         i_frac,
    input  logic [FRACTION_BITS-1:0]         i_saturation,
    input  logic [FRACTION_BITS-1:0]         i_brightness,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [FRACTION_BITS-1:0]         o_red,
    output logic [FRACTION_BITS-1:0]         o_green,
    output logic [FRACTION_BITS-1:0]         o_blue
);
    import hrgb_pkg::*;

    localparam int unsigned OW = FRACTION_BITS + 1;
    localparam int unsigned PW = 2 * FRACTION_BITS + 1;
    localparam logic [OW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    logic                     r_v4, r_v5, r_v6;
    logic                     en4, en5, en6;

    logic [OW-1:0]            n_inv_s, n_inv_f, n_inv_sf, n_inv_sg;
    logic [PW-1:0]            n_p_full, n_sf_full, n_sg_full, n_q_full, n_t_full;

    logic [SECTOR_W-1:0]      r4_sector, r5_sector;
    logic [FRACTION_BITS-1:0] r4_sf, r4_sg, r4_p;
    logic [FRACTION_BITS-1:0] r5_q, r5_t, r5_p;
    logic [FRACTION_BITS-1:0] n_red, n_green, n_blue;
    logic [FRACTION_BITS-1:0] r_red, r_green, r_blue;

    assign en6     = !r_v6 || i_ready;
    assign en5     = !r_v5 || en6;
    assign en4     = !r_v4 || en5;
    assign o_ready = en4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_valid;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // stage 4: p = v*(1-s), s*f, s*(1-f)
    assign n_inv_s   = ONE - OW'(i_saturation);
    assign n_inv_f   = ONE - OW'(i_frac);
    assign n_p_full  = PW'(i_brightness) * PW'(n_inv_s);
    assign n_sf_full = PW'(i_saturation) * PW'(i_frac);
    assign n_sg_full = PW'(i_saturation) * PW'(n_inv_f);

    // stage 5: q = v*(1-s*f), t = v*(1-s*(1-f))
    assign n_inv_sf  = ONE - OW'(r4_sf);
    assign n_inv_sg  = ONE - OW'(r4_sg);
    assign n_q_full  = PW'(i_brightness) * PW'(n_inv_sf);
    assign n_t_full  = PW'(i_brightness) * PW'(n_inv_sg);

    // stage 6: channel select, sector 5 shares the default arm
    always_comb begin
        case (r5_sector)
            SECTOR_0: begin n_red = i_brightness; n_green = r5_t; n_blue = r5_p; end
            SECTOR_1: begin n_red = r5_q; n_green = i_brightness; n_blue = r5_p; end
            SECTOR_2: begin n_red = r5_p; n_green = i_brightness; n_blue = r5_t; end
            SECTOR_3: begin n_red = r5_p; n_green = r5_q; n_blue = i_brightness; end
            SECTOR_4: begin n_red = r5_t; n_green = r5_p; n_blue = i_brightness; end
            default:  begin n_red = i_brightness; n_green = r5_p; n_blue = r5_q; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en4 && i_valid) begin
            r4_sector <= i_sector;
            r4_p      <= n_p_full[2*FRACTION_BITS-1:FRACTION_BITS];
            r4_sf     <= n_sf_full[2*FRACTION_BITS-1:FRACTION_BITS];
            r4_sg     <= n_sg_full[2*FRACTION_BITS-1:FRACTION_BITS];
        end
        if (en5 && r_v4) begin
            r5_sector <= r4_sector;
            r5_p      <= r4_p;
            r5_q      <= n_q_full[2*FRACTION_BITS-1:FRACTION_BITS];
            r5_t      <= n_t_full[2*FRACTION_BITS-1:FRACTION_BITS];
        end
        if (en6 && r_v5) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_v6;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

### rtl/core/hue_ramp_hsv_to_rgb_core.sv
// top level of the hue ramp hsv to rgb core
// depends on hrgb_pkg, hrgb_cfg_regs, hrgb_hue_pipe, hrgb_rgb_pipe
//
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_ready   i_ramp_position
//  out      source     o_out_valid / i_out_ready o_red, o_green, o_blue
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one beat in and one beat out per clock when the output side keeps ready high
// six register stages lie between input beat and output beat;
//   the multipliers of stages 1, 4 and 5 set the stage depth
// a stall on the output holds each full stage whose successor is full; empty stages still fill,
//   so up to six beats are taken while the output waits
// synchronous active-low reset empties the pipeline and sets every config
//   register to one half
module hue_ramp_hsv_to_rgb_core #(
    parameter int unsigned FRACTION_BITS = hrgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hrgb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [FRACTION_BITS-1:0]         i_cfg_data,
    // input beat
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [FRACTION_BITS-1:0]         i_ramp_position,
    // output beat
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [FRACTION_BITS-1:0]         o_red,
    output logic [FRACTION_BITS-1:0]         o_green,
    output logic [FRACTION_BITS-1:0]         o_blue
);
    import hrgb_pkg::*;

    // config values: user holds stable while beats are in flight; unenforced
    logic [FRACTION_BITS-1:0] hue_start;
    logic [FRACTION_BITS-1:0] hue_span;
    logic [FRACTION_BITS-1:0] saturation;
    logic [FRACTION_BITS-1:0] brightness;

    // hand-off between the hue half and the color half
    logic                     mid_valid;
    logic                     mid_ready;
    logic [SECTOR_W-1:0]      mid_sector;
    logic [FRACTION_BITS-1:0] mid_frac;

    hrgb_cfg_regs #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_hue_start  (hue_start),
        .o_hue_span   (hue_span),
        .o_saturation (saturation),
        .o_brightness (brightness)
    );

    // stages 1-3: hue = start + pos*span mod 1, then sector and fraction of 6*hue
    hrgb_hue_pipe #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_hue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_pos       (i_ramp_position),
        .i_hue_start (hue_start),
        .i_hue_span  (hue_span),
        .o_valid     (mid_valid),
        .i_ready     (mid_ready),
        .o_sector    (mid_sector),
        .o_frac      (mid_frac)
    );

    // stages 4-6: p, q, t terms, then pick per sector into the output register
    hrgb_rgb_pipe #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_rgb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (mid_valid),
        .o_ready      (mid_ready),
        .i_sector     (mid_sector),
        .i_frac       (mid_frac),
        .i_saturation (saturation),
        .i_brightness (brightness),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

endmodule

### rtl/core/hrgb_checker.sv
// port-level checks for the hue ramp hsv to rgb core, bound to the top level
// depends on hrgb_pkg and assert_macros.svh
`include "assert_macros.svh"

module hrgb_checker #(
    parameter int unsigned FRACTION_BITS = hrgb_pkg::FRACTION_BITS_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [hrgb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [FRACTION_BITS-1:0]         i_cfg_data,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [FRACTION_BITS-1:0]         o_red,
    input logic [FRACTION_BITS-1:0]         o_green,
    input logic [FRACTION_BITS-1:0]         o_blue
);
    import hrgb_pkg::*;

    localparam logic [FRACTION_BITS-1:0] HALF = {1'b1, {(FRACTION_BITS-1){1'b0}}};
    localparam int unsigned CW = $clog2(PIPE_DEPTH + 2);

    logic                     in_beat, out_beat;
    logic [CW-1:0]            r_cnt;
    logic [FRACTION_BITS-1:0] r_sat, r_brt;
    logic                     bright_hit;

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_beat = o_out_valid && i_out_ready;

    // beats in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_beat && !out_beat) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (out_beat && !in_beat) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // shadow of saturation and brightness
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= HALF;
            r_brt <= HALF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (t_cfg_idx'(i_cfg_index) == CFG_SATURATION) r_sat <= i_cfg_data;
            if (t_cfg_idx'(i_cfg_index) == CFG_BRIGHTNESS) r_brt <= i_cfg_data;
        end
    end

    assign bright_hit = (o_red == r_brt) || (o_green == r_brt) || (o_blue == r_brt);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue),
        "output beat changed while stalled")

    `ASSERT_IMPL(a_no_orphan_out, i_clk, i_rst_n, r_cnt == '0, !o_out_valid,
        "output beat with no input beat in flight")

    `ASSERT_CLK(a_depth_bound, i_clk, i_rst_n, r_cnt <= CW'(PIPE_DEPTH),
        "more beats in flight than pipeline stages")

    `ASSERT_IMPL(a_one_channel_bright, i_clk, i_rst_n, o_out_valid, bright_hit,
        "no channel equals brightness")

    `ASSERT_IMPL(a_gray_at_zero_sat, i_clk, i_rst_n, o_out_valid && (r_sat == '0),
        (o_red == r_brt) && (o_green == r_brt) && (o_blue == r_brt),
        "zero saturation did not give gray")

endmodule

bind hue_ramp_hsv_to_rgb_core hrgb_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_hrgb_checker (.*);
